// ===== rtl/fncd_pkg.sv =====
package fncd_pkg;

  localparam int CHANNEL_BITS = 8;
  localparam int PIXEL_BITS   = 3 * CHANNEL_BITS;
  localparam int DIFF_BITS    = CHANNEL_BITS + 2;

  localparam int THRESH_BITS  = 10;
  localparam int WIDTH_BITS   = 12;
  localparam int HEIGHT_BITS  = 13;
  localparam int CFG_DATA_BITS = 13;
  localparam int CFG_INDEX_BITS = 2;

  typedef logic [PIXEL_BITS-1:0]  pixel_t;
  typedef logic [DIFF_BITS-1:0]   diff_t;
  typedef logic [THRESH_BITS-1:0] thresh_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_WIDTH     = 2'd1,
    REG_HEIGHT    = 2'd2
  } reg_index_t;

  localparam logic [THRESH_BITS-1:0] THRESHOLD_RESET = 10'd5;
  localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET     = 12'd640;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET    = 13'd480;

  localparam logic [CHANNEL_BITS-1:0] VALUE_EDGE       = 8'd0;
  localparam logic [CHANNEL_BITS-1:0] VALUE_BACKGROUND = 8'd255;

  // neighbor slots in test order
  localparam int NB_LEFT   = 0;
  localparam int NB_RIGHT  = 1;
  localparam int NB_TOP    = 2;
  localparam int NB_BOTTOM = 3;
  localparam int NB_COUNT  = 4;

  function automatic diff_t chan_diff(input logic [CHANNEL_BITS-1:0] a,
                                      input logic [CHANNEL_BITS-1:0] b);
    logic [CHANNEL_BITS-1:0] d;
    d = (a > b) ? (a - b) : (b - a);
    return DIFF_BITS'(d);
  endfunction

  function automatic diff_t color_diff(input pixel_t a, input pixel_t b);
    return chan_diff(a[CHANNEL_BITS-1:0], b[CHANNEL_BITS-1:0])
         + chan_diff(a[2*CHANNEL_BITS-1:CHANNEL_BITS], b[2*CHANNEL_BITS-1:CHANNEL_BITS])
         + chan_diff(a[3*CHANNEL_BITS-1:2*CHANNEL_BITS],
                     b[3*CHANNEL_BITS-1:2*CHANNEL_BITS]);
  endfunction

endpackage

// ===== rtl/four_neighbor_color_edge_detect.sv =====
// Channel  Handshake               Payload
// pixel    pixel_valid/pixel_stall command, blue, green, red
// result   result_valid/result_stall out_value, end_of_frame
// cfg      cfg_valid/cfg_ready     cfg_index, cfg_data
//
// One item per cycle sustained while no result stalls. An item reads the
// row buffers at its accept edge, is judged in the next cycle and its result
// lands in the output register when the judge stage advances; the row buffer
// write-back feeds the next item through a forwarding register.
// rst is synchronous; the row buffers are not cleared and need one full row
// written before they are read. A stalled result holds the judge stage and
// then the pixel channel; items that give no result keep flowing.
module four_neighbor_color_edge_detect
  import fncd_pkg::*;
#(
  parameter int MAX_WIDTH = 2048
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      pixel_valid,
  output logic                      pixel_stall,
  input  logic                      command,
  input  logic [CHANNEL_BITS-1:0]   blue,
  input  logic [CHANNEL_BITS-1:0]   green,
  input  logic [CHANNEL_BITS-1:0]   red,
  output logic                      result_valid,
  input  logic                      result_stall,
  output logic [CHANNEL_BITS-1:0]   out_value,
  output logic                      end_of_frame,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [CFG_DATA_BITS-1:0]  cfg_data
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int CW = (AW + 1 > WIDTH_BITS) ? AW + 1 : WIDTH_BITS;

  typedef struct packed {
    logic [AW-1:0]       col;
    logic                last_col;
    logic                has_res;
    logic                draining;
    logic [NB_COUNT-1:0] in_image;
    logic                hit_center;
    logic                hit_right;
    logic                hit_top;
    pixel_t              cur;
  } stage_t;

  // configuration
  thresh_t                threshold;
  logic [WIDTH_BITS-1:0]  image_width;
  logic [HEIGHT_BITS-1:0] image_height;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold    <= THRESHOLD_RESET;
      image_width  <= WIDTH_RESET;
      image_height <= HEIGHT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (reg_index_t'(cfg_index))
        REG_THRESHOLD: threshold    <= cfg_data[THRESH_BITS-1:0];
        REG_WIDTH:     image_width  <= cfg_data[WIDTH_BITS-1:0];
        REG_HEIGHT:    image_height <= cfg_data[HEIGHT_BITS-1:0];
        default: ;
      endcase
    end
  end

  // position in frame
  logic [AW-1:0]          column_count;
  logic [HEIGHT_BITS-1:0] row_count;
  logic [CW-1:0]          w_eff;
  logic [CW-1:0]          c_ext;
  logic [HEIGHT_BITS-1:0] h_eff;
  logic [AW-1:0]          col;
  logic [AW-1:0]          col_right;
  logic                   last_col;
  logic                   draining;
  logic                   counts;
  logic                   take;
  logic                   load;

  always_comb begin
    if (image_width == '0) begin
      w_eff = CW'(1);
    end else if (CW'(image_width) > CW'(MAX_WIDTH)) begin
      w_eff = CW'(MAX_WIDTH);
    end else begin
      w_eff = CW'(image_width);
    end
    h_eff = (image_height == '0) ? HEIGHT_BITS'(1) : image_height;
    c_ext = (CW'(column_count) >= w_eff) ? (w_eff - CW'(1)) : CW'(column_count);
    col       = c_ext[AW-1:0];
    col_right = col + AW'(1);
    last_col  = (c_ext + CW'(1)) >= w_eff;
    draining  = row_count >= h_eff;
  end

  // judge stage
  logic    s1_valid;
  stage_t  s1;
  logic    s1_adv;
  pixel_t  left_pixel;
  pixel_t  fwd_prev;
  pixel_t  fwd_top;
  pixel_t  prev_c_q;
  pixel_t  prev_r_q;
  pixel_t  top_q;
  pixel_t  center;
  pixel_t  prev_wdata;
  pixel_t  [NB_COUNT-1:0] nbr;
  logic    is_edge;

  assign s1_adv      = s1_valid && (!s1.has_res || !result_valid || !result_stall);
  assign pixel_stall = s1_valid && !s1_adv;
  assign take        = pixel_valid && !pixel_stall;
  // a pixel while draining, or a flush before the last row is in, is dropped
  assign counts      = (cmd_t'(command) == CMD_FLUSH) == draining;
  assign load        = take && counts;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (load) begin
      if (last_col) begin
        column_count <= '0;
        row_count    <= draining ? '0 : row_count + HEIGHT_BITS'(1);
      end else begin
        column_count <= col_right;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  // reads are issued at the accept edge; the write-back of the item leaving
  // the judge stage at that same edge is forwarded
  always_ff @(posedge clk) begin
    if (load) begin
      s1.col                 <= col;
      s1.last_col            <= last_col;
      s1.has_res             <= row_count != '0;
      s1.draining            <= draining;
      s1.in_image[NB_LEFT]   <= col != '0;
      s1.in_image[NB_RIGHT]  <= !last_col;
      s1.in_image[NB_TOP]    <= row_count >= HEIGHT_BITS'(2);
      s1.in_image[NB_BOTTOM] <= !draining;
      s1.hit_center          <= s1_adv && (s1.col == col);
      s1.hit_right           <= s1_adv && (s1.col == col_right);
      s1.hit_top             <= s1_adv && (s1.col == col);
      s1.cur                 <= {red, green, blue};
    end
  end

  assign prev_wdata = s1.draining ? '0 : s1.cur;

  fncd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_prev_center (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1.col),
    .wr_data (prev_wdata),
    .rd_en   (load),
    .rd_addr (col),
    .rd_data (prev_c_q)
  );

  // copy of the previous row for the right-hand neighbor read
  fncd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_prev_right (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1.col),
    .wr_data (prev_wdata),
    .rd_en   (load),
    .rd_addr (col_right),
    .rd_data (prev_r_q)
  );

  fncd_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_row_before (
    .clk     (clk),
    .wr_en   (s1_adv),
    .wr_addr (s1.col),
    .wr_data (center),
    .rd_en   (load),
    .rd_addr (col),
    .rd_data (top_q)
  );

  always_comb begin
    center            = s1.hit_center ? fwd_prev : prev_c_q;
    nbr[NB_LEFT]      = left_pixel;
    nbr[NB_RIGHT]     = s1.hit_right ? fwd_prev : prev_r_q;
    nbr[NB_TOP]       = s1.hit_top ? fwd_top : top_q;
    nbr[NB_BOTTOM]    = s1.cur;
  end

  fncd_judge u_judge (
    .center    (center),
    .nbr       (nbr),
    .in_image  (s1.in_image),
    .threshold (threshold),
    .is_edge   (is_edge)
  );

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      fwd_prev <= prev_wdata;
      fwd_top  <= center;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      left_pixel <= '0;
    end else if (s1_adv) begin
      left_pixel <= s1.last_col ? '0 : center;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (s1_adv && s1.has_res) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1.has_res) begin
      out_value    <= is_edge ? VALUE_EDGE : VALUE_BACKGROUND;
      end_of_frame <= s1.draining && s1.last_col;
    end
  end

  assert property (@(posedge clk) disable iff (rst) pixel_stall |-> s1_valid)
    else $error("pixel channel stalled with an empty judge stage");

  assert property (@(posedge clk) disable iff (rst) load |=> s1_valid)
    else $error("counted item did not enter the judge stage");

  assert property (@(posedge clk) disable iff (rst)
                   (s1_adv && s1.has_res) |-> !(result_valid && result_stall))
    else $error("result overwrote a stalled output item");

  assert property (@(posedge clk) disable iff (rst)
                   (load && last_col) |=> (column_count == '0))
    else $error("column count did not wrap at the end of a row");

endmodule

// ===== rtl/fncd_ram.sv =====
module fncd_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read-before-write on a same-address collision
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/fncd_judge.sv =====
module fncd_judge
  import fncd_pkg::*;
(
  input  pixel_t                center,
  input  pixel_t [NB_COUNT-1:0] nbr,
  input  logic   [NB_COUNT-1:0] in_image,
  input  thresh_t               threshold,
  output logic                  is_edge
);

  logic [NB_COUNT-1:0] over;
  logic [NB_COUNT-1:0] reach;

  always_comb begin
    for (int k = 0; k < NB_COUNT; k++) begin
      over[k] = color_diff(center, nbr[k]) > DIFF_BITS'(threshold);
    end
  end

  // a neighbor counts only if it and every earlier one lie inside and
  // no earlier one already decided
  always_comb begin
    reach[0] = in_image[0];
    for (int k = 1; k < NB_COUNT; k++) begin
      reach[k] = reach[k-1] & ~over[k-1] & in_image[k];
    end
  end

  assign is_edge = |(reach & over);

endmodule
